// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

    // Capacity register geometry, fixed by the register map.
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Default build geometry.
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // Request kinds.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

endpackage

// ===== rtl/lkvc_channels.sv =====
interface lkvc_req_if
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] store_value;

    modport source (output valid, output req_type, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input req_type, input lookup_key, input store_value,
                    output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/lkvc_cell.sv =====
// One slot of the recency-ordered chain. A load takes the neighbor's entry.
module lkvc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  in_valid,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [KEY_BITS-1:0]   lookup_key,
    output logic                  out_valid,
    output logic [KEY_BITS-1:0]   out_key,
    output logic [VALUE_BITS-1:0] out_value,
    output logic                  match
);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    assign match     = valid_reg && (key_reg == lookup_key);
    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_value = value_reg;

endmodule

// ===== rtl/lkvc_hit_select.sv =====
// Encodes the one-hot match vector and picks the matching value.
module lkvc_hit_select #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4,
    parameter int VALUE_BITS  = 32
) (
    input  logic [MAX_ENTRIES-1:0]                 match,
    input  logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] values,
    output logic                                   any_hit,
    output logic [IDX_W-1:0]                       hit_idx,
    output logic [VALUE_BITS-1:0]                  hit_value
);

    always_comb
    begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_idx   = hit_idx | (IDX_W'(i) & {IDX_W{match[i]}});
            hit_value = hit_value | (values[i] & {VALUE_BITS{match[i]}});
        end
    end

    assign any_hit = |match;

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// Response: a get is answered from the output register in the cycle after its request beat.
// Throughput: one request per cycle while the response side keeps up; the key compare,
//   one-hot select and the one-step shift of the cell chain all settle in the cycle of the request beat.
// Reset: every cell is empty, the entry count is zero and capacity reads 16. Stored keys
//   and values are not cleared, so no clearing pass runs and requests are taken at once.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    lkvc_req_if.sink         req,
    lkvc_rsp_if.source       rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // The cells form a list ordered by recency: cell 0 holds the most recently used
    // entry and the valid cells are always a prefix of the chain. Making an entry the
    // most recent, or adding one, is a one-step shift of a prefix of the chain, with the
    // new head entering cell 0. Dropping the tail of that prefix is the eviction.

    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_hit_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic [MAX_ENTRIES-1:0]                 cell_valid;
    logic [MAX_ENTRIES-1:0][KEY_BITS-1:0]   cell_key;
    logic [MAX_ENTRIES-1:0][VALUE_BITS-1:0] cell_value;
    logic [MAX_ENTRIES-1:0]                 cell_match;
    logic [MAX_ENTRIES-1:0]                 cell_load;

    logic                  any_hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [VALUE_BITS-1:0] hit_value;

    logic                  req_beat;
    logic                  is_set;
    logic                  chain_active;
    logic [CNT_W-1:0]      used_cap;
    logic [CNT_W-1:0]      insert_count;
    logic [IDX_W-1:0]      shift_last;
    logic [VALUE_BITS-1:0] head_value;

    // The output register frees as it is drained, so a new request can be taken in the
    // same cycle that the pending response leaves.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign req_beat  = req.valid && req.ready;
    assign is_set    = (req.req_type == REQ_SET);

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            used_cap = CNT_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES))
        begin
            used_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            used_cap = CNT_W'(capacity_reg);
        end
    end

    // When the store is full, or holds more than a lowered capacity allows, an insert
    // keeps the count and the shift pushes the least recent entry off the prefix.
    assign insert_count = (count_reg >= used_cap) ? count_reg : count_reg + CNT_W'(1);

    lkvc_hit_select #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .VALUE_BITS  (VALUE_BITS)
    ) u_hit_select (
        .match     (cell_match),
        .values    (cell_value),
        .any_hit   (any_hit),
        .hit_idx   (hit_idx),
        .hit_value (hit_value)
    );

    // A hit rotates cells 0 through the hit position; an insert shifts up to the new
    // last valid position. A get miss leaves the chain untouched.
    assign chain_active = req_beat && (any_hit || is_set);
    assign shift_last   = any_hit ? hit_idx : IDX_W'(insert_count - CNT_W'(1));
    assign head_value   = is_set ? req.store_value : hit_value;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            cell_load[i] = chain_active && (IDX_W'(i) <= shift_last);
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic                  left_valid;
        logic [KEY_BITS-1:0]   left_key;
        logic [VALUE_BITS-1:0] left_value;

        if (g == 0)
        begin : g_head
            assign left_valid = 1'b1;
            assign left_key   = req.lookup_key;
            assign left_value = head_value;
        end
        else
        begin : g_link
            assign left_valid = cell_valid[g-1];
            assign left_key   = cell_key[g-1];
            assign left_value = cell_value[g-1];
        end

        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (cell_load[g]),
            .in_valid   (left_valid),
            .in_key     (left_key),
            .in_value   (left_value),
            .lookup_key (req.lookup_key),
            .out_valid  (cell_valid[g]),
            .out_key    (cell_key[g]),
            .out_value  (cell_value[g]),
            .match      (cell_match[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (req_beat && is_set && !any_hit)
        begin
            count_next = insert_count;
        end
    end

    // A get always produces a response beat; a set produces none.
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (req_beat && !is_set)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload; a miss reads back as all ones.
    always_ff @(posedge clk)
    begin
        if (req_beat && !is_set)
        begin
            out_hit_reg   <= any_hit;
            out_value_reg <= any_hit ? hit_value : '1;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_value_reg;

    // The valid cells match the entry count, and keys stay unique.
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_match))
        else $error("key matched in more than one cell");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & ~(cell_valid >> 1)) == (cell_valid ^ (cell_valid >> 1)))
        else $error("valid cells do not form a prefix of the chain");

    a_get_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && !is_set) |=> out_valid_reg)
        else $error("get request produced no response");

    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && is_set && !out_valid_reg) |=> !out_valid_reg)
        else $error("set request produced a response");

endmodule
